@@ rtl/tccw_pkg.sv @@
package tccw_pkg;

	// default screen geometry
	localparam int unsigned DEF_SCREEN_COLUMNS = 80;
	localparam int unsigned DEF_SCREEN_ROWS    = 25;

	// linear cell index wide enough for the largest screen (64 x 128)
	localparam int unsigned LIN_W = 13;

	localparam int unsigned CMD_FIFO_DEPTH = 2;

	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_SPACE     = 8'd32;
	localparam logic [7:0] COLOR_RESET    = 8'h07;

	// byte address of the text color register
	localparam logic [2:0] REG_TEXT_COLOR_ADDR = 3'd0;

	typedef enum logic [1:0] {
		ACT_PUT        = 2'd0,
		ACT_SET_CURSOR = 2'd1,
		ACT_CLEAR      = 2'd2,
		ACT_READ       = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_GLYPH,
		CMD_NEWLINE,
		CMD_BACKSPACE,
		CMD_SET,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	// classified request as it sits in the queue
	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       glyph;
		logic             in_range;
		logic [5:0]       row;
		logic [6:0]       col;
		logic [LIN_W-1:0] lin;
	} cmd_t;

endpackage

@@ rtl/tccw_ram.sv @@
module tccw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tccw_front.sv @@
module tccw_front import tccw_pkg::*; #(
	parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] action,
	input  logic [7:0] char_code,
	input  logic [5:0] row,
	input  logic [6:0] column,
	input  logic       fifo_full,
	input  logic       init_busy,
	output logic       push,
	output cmd_t       push_cmd
);

	assign req_ready = !fifo_full && !init_busy;
	assign push      = req_valid && req_ready;

	always_comb begin
		push_cmd.glyph    = char_code;
		push_cmd.row      = row;
		push_cmd.col      = column;
		push_cmd.lin      = LIN_W'(row) * LIN_W'(SCREEN_COLUMNS) + LIN_W'(column);
		push_cmd.in_range = (7'(row) < 7'(SCREEN_ROWS)) && (8'(column) < 8'(SCREEN_COLUMNS));
		case (action_t'(action))
			ACT_PUT: begin
				if (char_code == CODE_NEWLINE) begin
					push_cmd.kind = CMD_NEWLINE;
				end else if (char_code == CODE_BACKSPACE) begin
					push_cmd.kind = CMD_BACKSPACE;
				end else begin
					push_cmd.kind = CMD_GLYPH;
				end
			end
			ACT_SET_CURSOR: push_cmd.kind = CMD_SET;
			ACT_CLEAR:      push_cmd.kind = CMD_CLEAR;
			ACT_READ:       push_cmd.kind = CMD_READ;
			default:        push_cmd.kind = CMD_READ;
		endcase
	end

endmodule

@@ rtl/tccw_cmd_fifo.sv @@
module tccw_cmd_fifo import tccw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             slot_q [CMD_FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(CMD_FIFO_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tccw_back.sv @@
module tccw_back import tccw_pkg::*; #(
	parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_color,
	input  cmd_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        init_busy,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [10:0] cursor_position,
	output logic [15:0] cell_data
);

	localparam int unsigned CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int unsigned BASE  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
	localparam int unsigned AW    = $clog2(CELLS);
	localparam int unsigned RW    = $clog2(SCREEN_ROWS);
	localparam int unsigned CW    = $clog2(SCREEN_COLUMNS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_FILL
	} state_t;

	typedef enum logic [1:0] {
		FILL_INIT,
		FILL_CLEAR,
		FILL_BOTTOM
	} fill_kind_t;

	state_t         state_q;
	fill_kind_t     fill_kind_q;
	logic [AW-1:0]  fill_ptr_q;
	logic [15:0]    fill_cell_q;
	logic [AW-1:0]  src_q;
	logic           cp_valid_s1;
	logic [AW-1:0]  cp_dst_s1;
	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  cur_col_q;
	logic [AW-1:0]  cur_addr_q;
	logic           rsp_valid_q;
	logic [4:0]     orow_q;
	logic [6:0]     ocol_q;
	logic [10:0]    opos_q;
	logic [15:0]    odata_q;

	logic           at_last_col;
	logic           at_last_row;
	logic [RW-1:0]  nxt_row;
	logic [CW-1:0]  nxt_col;
	logic [AW-1:0]  nxt_addr;
	logic           ex_scroll;
	logic           idle_we;
	logic [15:0]    idle_wdata;
	logic [RW-1:0]  rep_row;
	logic [CW-1:0]  rep_col;
	logic [AW-1:0]  rep_addr;
	logic [RW+4:0]  row_ext;
	logic [CW+6:0]  col_ext;
	logic [AW+10:0] addr_ext;
	logic           rsp_set;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [15:0]    mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [15:0]    mem_rdata;

	assign pop       = (state_q == ST_IDLE) && !empty && (!rsp_valid_q || rsp_ready);
	assign init_busy = (state_q == ST_FILL) && (fill_kind_q == FILL_INIT);

	assign at_last_col = (cur_col_q == CW'(SCREEN_COLUMNS - 1));
	assign at_last_row = (cur_row_q == RW'(SCREEN_ROWS - 1));

	// cursor move for the request at the queue head
	always_comb begin
		nxt_row    = cur_row_q;
		nxt_col    = cur_col_q;
		nxt_addr   = cur_addr_q;
		ex_scroll  = 1'b0;
		idle_we    = 1'b0;
		idle_wdata = {text_color, CODE_SPACE};
		case (head.kind)
			CMD_GLYPH: begin
				idle_we    = 1'b1;
				idle_wdata = {text_color, head.glyph};
				if (at_last_col) begin
					nxt_col   = '0;
					ex_scroll = at_last_row;
					if (at_last_row) begin
						nxt_addr = AW'(BASE);
					end else begin
						nxt_row  = cur_row_q + 1'b1;
						nxt_addr = cur_addr_q + 1'b1;
					end
				end else begin
					nxt_col  = cur_col_q + 1'b1;
					nxt_addr = cur_addr_q + 1'b1;
				end
			end
			CMD_NEWLINE: begin
				nxt_col   = '0;
				ex_scroll = at_last_row;
				if (at_last_row) begin
					nxt_addr = AW'(BASE);
				end else begin
					nxt_row  = cur_row_q + 1'b1;
					nxt_addr = cur_addr_q - AW'(cur_col_q) + AW'(SCREEN_COLUMNS);
				end
			end
			CMD_BACKSPACE: begin
				idle_we = 1'b1;
				if (cur_col_q != '0) begin
					nxt_col  = cur_col_q - 1'b1;
					nxt_addr = cur_addr_q - 1'b1;
				end else if (cur_row_q != '0) begin
					nxt_row  = cur_row_q - 1'b1;
					nxt_col  = CW'(SCREEN_COLUMNS - 1);
					nxt_addr = cur_addr_q - 1'b1;
				end
			end
			CMD_SET: begin
				if (head.in_range) begin
					nxt_row  = head.row[RW-1:0];
					nxt_col  = head.col[CW-1:0];
					nxt_addr = head.lin[AW-1:0];
				end
			end
			CMD_CLEAR: begin
				nxt_row  = '0;
				nxt_col  = '0;
				nxt_addr = '0;
			end
			default: begin
			end
		endcase
	end

	// screen store ports: fill sweep, scroll copy, or the single write or read of a request
	always_comb begin
		mem_we    = (state_q == ST_FILL) || cp_valid_s1 || (pop && idle_we);
		mem_waddr = nxt_addr;
		mem_wdata = idle_wdata;
		if (state_q == ST_FILL) begin
			mem_waddr = fill_ptr_q;
			mem_wdata = fill_cell_q;
		end else if (cp_valid_s1) begin
			mem_waddr = cp_dst_s1;
			mem_wdata = mem_rdata;
		end else if (head.kind == CMD_GLYPH) begin
			mem_waddr = cur_addr_q;
		end
		mem_re    = (state_q == ST_COPY) || (pop && (head.kind == CMD_READ) && head.in_range);
		mem_raddr = (state_q == ST_COPY) ? src_q : head.lin[AW-1:0];
	end

	tccw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// reported cursor, cut to the output widths
	always_comb begin
		rep_row  = (state_q == ST_IDLE) ? nxt_row : cur_row_q;
		rep_col  = (state_q == ST_IDLE) ? nxt_col : cur_col_q;
		rep_addr = (state_q == ST_IDLE) ? nxt_addr : cur_addr_q;
		row_ext  = {5'b0, rep_row};
		col_ext  = {7'b0, rep_col};
		addr_ext = {11'b0, rep_addr};
	end

	// response is loaded when a request finishes
	always_comb begin
		case (state_q)
			ST_IDLE: rsp_set = pop && (head.kind != CMD_CLEAR) && !ex_scroll &&
				!((head.kind == CMD_READ) && head.in_range);
			ST_READ: rsp_set = 1'b1;
			ST_FILL: rsp_set = (fill_ptr_q == AW'(CELLS - 1)) && (fill_kind_q != FILL_INIT);
			default: rsp_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_kind_q <= FILL_INIT;
			fill_ptr_q  <= '0;
			fill_cell_q <= {COLOR_RESET, CODE_SPACE};
			src_q       <= '0;
			cp_valid_s1 <= 1'b0;
			cp_dst_s1   <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cur_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
			orow_q      <= '0;
			ocol_q      <= '0;
			opos_q      <= '0;
			odata_q     <= '0;
		end else begin
			cp_valid_s1 <= (state_q == ST_COPY);
			cp_dst_s1   <= src_q - AW'(SCREEN_COLUMNS);
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_row_q  <= nxt_row;
						cur_col_q  <= nxt_col;
						cur_addr_q <= nxt_addr;
						if (head.kind == CMD_CLEAR) begin
							state_q     <= ST_FILL;
							fill_kind_q <= FILL_CLEAR;
							fill_ptr_q  <= '0;
							fill_cell_q <= {text_color, CODE_SPACE};
						end else if (ex_scroll) begin
							state_q <= ST_COPY;
							src_q   <= AW'(SCREEN_COLUMNS);
						end else if ((head.kind == CMD_READ) && head.in_range) begin
							state_q <= ST_READ;
						end else begin
							orow_q      <= row_ext[4:0];
							ocol_q      <= col_ext[6:0];
							opos_q      <= addr_ext[10:0];
							odata_q     <= '0;
						end
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					orow_q      <= row_ext[4:0];
					ocol_q      <= col_ext[6:0];
					opos_q      <= addr_ext[10:0];
					odata_q     <= mem_rdata;
				end
				ST_COPY: begin
					if (src_q == AW'(CELLS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						src_q <= src_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q     <= ST_FILL;
					fill_kind_q <= FILL_BOTTOM;
					fill_ptr_q  <= AW'(BASE);
					fill_cell_q <= {text_color, CODE_SPACE};
				end
				ST_FILL: begin
					if (fill_ptr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
						if (fill_kind_q != FILL_INIT) begin
							orow_q      <= row_ext[4:0];
							ocol_q      <= col_ext[6:0];
							opos_q      <= addr_ext[10:0];
							odata_q     <= '0;
						end
					end else begin
						fill_ptr_q <= fill_ptr_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign cursor_row      = orow_q;
	assign cursor_column   = ocol_q;
	assign cursor_position = opos_q;
	assign cell_data       = odata_q;

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_pop_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!rsp_valid_q || rsp_ready))
		else $error("pop while response still pending");

	a_cursor_lin: assert property (@(posedge clk) disable iff (!arst_n)
		cur_addr_q == (AW'(cur_row_q) * AW'(SCREEN_COLUMNS) + AW'(cur_col_q)))
		else $error("cursor linear address out of step with row/column");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_row_q} < (RW+1)'(SCREEN_ROWS)) &&
		({1'b0, cur_col_q} < (CW+1)'(SCREEN_COLUMNS)))
		else $error("cursor off screen");

	a_copy_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> ($past(state_q) == ST_COPY) && (state_q != ST_FILL))
		else $error("scroll copy write without matching read");
`endif

endmodule

@@ rtl/text_console_cell_writer_core.sv @@
// Text console cell writer: a SCREEN_ROWS x SCREEN_COLUMNS screen store of
// 16-bit cells (attribute high byte, character low byte) plus a cursor.
// Requests (put char, set cursor, clear, read cell) go through a two-deep
// queue to an execution unit that owns the cursor and the store; every
// request yields one response carrying the cursor after it and, for reads,
// the cell. Back-to-back put, newline, backspace and set cursor requests
// that do not scroll run at one per cycle while rsp_ready stays high; an
// in-range read also passes through a read state (registered RAM read).
// The sweeps go one cell at a time through the store's single write port:
// a scroll (newline or row-end wrap on the last row) copies rows 1 to
// SCREEN_ROWS-1 up by one row and then blanks the bottom row, and clear
// blanks every cell. After reset the store is swept to space/0x07 (2000
// cells at the default 80x25); req_ready stays low until it ends. The
// text_color register (APB, byte address 0) should only be written with no
// request in flight.
module text_console_cell_writer_core import tccw_pkg::*; #(
	parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int unsigned SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [5:0]  row,
	input  logic [6:0]  column,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [10:0] cursor_position,
	output logic [15:0] cell_data
);

	logic [7:0] text_color_q;
	logic       push;
	cmd_t       push_cmd;
	cmd_t       head;
	logic       pop;
	logic       empty;
	logic       full;
	logic       init_busy;

	// config register: written in the APB access phase, zero-wait
	assign pready = 1'b1;
	assign prdata = (paddr == REG_TEXT_COLOR_ADDR) ? {24'b0, text_color_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_TEXT_COLOR_ADDR)) begin
			text_color_q <= pwdata[7:0];
		end
	end

	// front: accept and classify requests
	tccw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_front (
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action   (action),
		.char_code(char_code),
		.row      (row),
		.column   (column),
		.fifo_full(full),
		.init_busy(init_busy),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouples the front from long scroll/clear sweeps
	tccw_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	// back: cursor, screen store, response register
	tccw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_color     (text_color_q),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.init_busy      (init_busy),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column),
		.cursor_position(cursor_position),
		.cell_data      (cell_data)
	);

endmodule
